// File: rtl/ndd_pkg.sv
package ndd_pkg;

    // item geometry
    localparam int MAX_POINTS    = 5;
    localparam int NODE_COUNT    = 5;
    localparam int NODE_LIM      = (NODE_COUNT < MAX_POINTS) ? NODE_COUNT : MAX_POINTS;
    localparam int FRACTION_BITS = 48;
    localparam int SHIFT         = FRACTION_BITS - 16;

    // field widths
    localparam int CNT_W      = 3;
    localparam int SEL_W      = 3;
    localparam int SPACE_W    = 18;
    localparam int SAMPLE_W   = 32;
    localparam int QX_W       = 21;
    localparam int VALUE_W    = 48;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // internal widths
    localparam int X_W    = SEL_W + SPACE_W;
    localparam int DX_W   = X_W + 1;
    localparam int M_W    = X_W + 2;
    localparam int UM_W   = M_W - 1;
    localparam int IN_W   = 64;
    localparam int MAG_W  = IN_W - 2;
    localparam int PROD_W = MAG_W + UM_W;
    localparam int DIV_W  = (SAMPLE_W + 1 + SHIFT > IN_W - 1) ? SAMPLE_W + 1 + SHIFT : IN_W - 1;

    // pipeline shape
    localparam int DIV_BPS = 4;
    localparam int DIV_ST  = (DIV_W + DIV_BPS - 1) / DIV_BPS;
    localparam int LVL_LAT = DIV_ST + 3;
    localparam int HRN_LAT = 5;

    localparam logic [IN_W-1:0]    INNER_LIM_U = {2'b00, {MAG_W{1'b1}}};
    localparam logic [VALUE_W-1:0] OUT_LIM_U   = {1'b0, {(VALUE_W-1){1'b1}}};

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_NODE_SPACING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_0     = 3'd1;

    localparam logic [SPACE_W-1:0] SPACING_RST = 18'd20000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_RST [MAX_POINTS] =
        '{32'sd642908, 32'sd638851, 32'sd634906, 32'sd634906, 32'sd627062};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_REPEAT    = 2'd2,
        ST_SAT       = 2'd3
    } t_status;

    // per-item data that travels beside the arithmetic
    typedef struct packed {
        logic [CNT_W-1:0]                  cnt;
        logic [MAX_POINTS-1:0][X_W-1:0]    xs;
        logic signed [QX_W-1:0]            qx;
        logic                              bad;
        logic                              dup;
        logic                              sat;
        logic [MAX_POINTS-1:0][IN_W-1:0]   coef;
    } t_side;

endpackage

// File: rtl/ndd_div.sv
module ndd_div import ndd_pkg::*; #(
    parameter int DW  = DIV_W,
    parameter int VW  = X_W,
    parameter int BPS = DIV_BPS,
    parameter int TW  = 1
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [TW-1:0] i_tag,
    output logic [DW-1:0] o_quotient,
    output logic [TW-1:0] o_tag
);

    localparam int ST = (DW + BPS - 1) / BPS;
    localparam int PW = ST * BPS;

    logic [VW-1:0] r_rem  [ST];
    logic [PW-1:0] r_work [ST];
    logic [VW-1:0] r_dvs  [ST];
    logic [TW-1:0] r_tag  [ST];

    for (genvar g = 0; g < ST; g++) begin : g_st
        logic [VW-1:0] s_rem;
        logic [VW-1:0] s_dvs;
        logic [PW-1:0] s_work;
        logic [TW-1:0] s_tag;
        logic [VW-1:0] n_rem;
        logic [PW-1:0] n_work;

        if (g == 0) begin : g_head
            assign s_rem  = '0;
            assign s_work = PW'(i_dividend);
            assign s_dvs  = i_divisor;
            assign s_tag  = i_tag;
        end else begin : g_body
            assign s_rem  = r_rem[g-1];
            assign s_work = r_work[g-1];
            assign s_dvs  = r_dvs[g-1];
            assign s_tag  = r_tag[g-1];
        end

        // restoring steps, quotient bits shift in as dividend bits shift out
        always_comb begin
            logic [VW:0] t;
            n_rem  = s_rem;
            n_work = s_work;
            for (int b = 0; b < BPS; b++) begin
                t      = {n_rem, n_work[PW-1]};
                n_work = {n_work[PW-2:0], 1'b0};
                if (t >= {1'b0, s_dvs}) begin
                    t         = t - {1'b0, s_dvs};
                    n_work[0] = 1'b1;
                end
                n_rem = t[VW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_work[g] <= n_work;
            r_dvs[g]  <= s_dvs;
            r_tag[g]  <= s_tag;
        end
    end

    assign o_quotient = r_work[ST-1][DW-1:0];
    assign o_tag      = r_tag[ST-1];

endmodule

// File: rtl/ndd_mul.sv
module ndd_mul import ndd_pkg::*; #(
    parameter int AW = MAG_W,
    parameter int BW = UM_W
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int LW = AW / 2;
    localparam int HW = AW - LW;

    logic [LW+BW-1:0] r_lo;
    logic [HW+BW-1:0] r_hi;
    logic [AW+BW-1:0] r_p;

    // two partial products, then one wide add
    always_ff @(posedge i_clk) begin
        r_lo <= i_a[LW-1:0] * i_b;
        r_hi <= i_a[AW-1:LW] * i_b;
        r_p  <= {r_hi, {LW{1'b0}}} + (AW+BW)'(r_lo);
    end

    assign o_p = r_p;

endmodule

// File: rtl/newton_divided_difference_interp_top.sv
// newton divided-difference interpolator
//
// input channel: a word (point count, five node selectors, query abscissa) is
// taken at a rising edge with start high and busy low. busy is low whenever
// reset is released, so a new word may be issued every cycle.
// node j sits at selector * node_spacing, its ordinate comes from the sample
// registers. the tableau is built by four levels of pipelined dividers
// (4 quotient bits per stage, 17 stages per divider), then the newton form is
// evaluated by three horner steps of 5 stages each and a final scaling step.
// o_strobe rises once the word has passed the load stage, the four levels,
// the horner steps, the scaling step and the output register; throughput is
// one word per cycle, set by the fully pipelined divider and multiplier lanes.
// output channel: o_value / o_status hold a result for one cycle marked by
// o_strobe; the receiver cannot stall, so nothing ever waits in the pipe.
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx at once,
// meant for idle periods; indexes past the last sample register are ignored.
// reset clears all valid bits and loads the default spacing and samples.
module newton_divided_difference_interp_top import ndd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [CNT_W-1:0]           i_point_count,
    input  logic [SEL_W-1:0]           i_node_0,
    input  logic [SEL_W-1:0]           i_node_1,
    input  logic [SEL_W-1:0]           i_node_2,
    input  logic [SEL_W-1:0]           i_node_3,
    input  logic [SEL_W-1:0]           i_node_4,
    input  logic signed [QX_W-1:0]     i_query_x,
    output logic                       o_strobe,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic [STATUS_W-1:0]        o_status
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [SPACE_W-1:0]         r_spacing;
    logic signed [SAMPLE_W-1:0] r_sample [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RST;
            for (int e = 0; e < MAX_POINTS; e++) begin
                r_sample[e] <= SAMPLE_RST[e];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NODE_SPACING) begin
                r_spacing <= i_cfg_data[SPACE_W-1:0];
            end
            for (int e = 0; e < MAX_POINTS; e++) begin
                if (i_cfg_idx == CFG_IDX_W'(int'(REG_SAMPLE_0) + e)) begin
                    r_sample[e] <= $signed(i_cfg_data[SAMPLE_W-1:0]);
                end
            end
        end
    end

    assign busy = !i_rst_n;

    // ---------------------------------------------------------------
    // load stage: abscissas, ordinates, count and repeat checks
    // ---------------------------------------------------------------
    logic [SEL_W-1:0] w_sel [MAX_POINTS];

    assign w_sel[0] = i_node_0;
    assign w_sel[1] = i_node_1;
    assign w_sel[2] = i_node_2;
    assign w_sel[3] = i_node_3;
    assign w_sel[4] = i_node_4;

    t_side                  n_side0;
    logic signed [IN_W-1:0] n_y [MAX_POINTS];
    t_side                  r_side0;
    logic signed [IN_W-1:0] r_cur0 [MAX_POINTS];
    logic                   r_vld0;

    always_comb begin
        n_side0     = '0;
        n_side0.cnt = i_point_count;
        n_side0.qx  = i_query_x;
        n_side0.bad = (i_point_count < CNT_W'(2)) || (i_point_count > CNT_W'(MAX_POINTS));
        for (int i = 0; i < MAX_POINTS; i++) begin
            n_side0.xs[i] = X_W'(w_sel[i]) * X_W'(r_spacing);
            n_y[i] = '0;
            // selectors past the sample table read as zero ordinate
            for (int e = 0; e < NODE_LIM; e++) begin
                if (w_sel[i] == SEL_W'(e)) begin
                    n_y[i] = IN_W'(r_sample[e]);
                end
            end
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            for (int j = i + 1; j < MAX_POINTS; j++) begin
                if ((int'(i_point_count) > j) &&
                    ((w_sel[i] == w_sel[j]) || (r_spacing == '0))) begin
                    n_side0.dup = 1'b1;
                end
            end
        end
        n_side0.coef[0] = n_y[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side0 <= n_side0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            r_cur0[i] <= n_y[i];
        end
    end

    // ---------------------------------------------------------------
    // divided-difference levels
    // ---------------------------------------------------------------
    t_side                  w_side [MAX_POINTS];
    logic                   w_vld  [MAX_POINTS];
    logic signed [IN_W-1:0] w_cur  [MAX_POINTS][MAX_POINTS];

    assign w_side[0] = r_side0;
    assign w_vld[0]  = r_vld0;
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cur0
        assign w_cur[0][i] = r_cur0[i];
    end

    for (genvar k = 1; k < MAX_POINTS; k++) begin : g_lvl
        localparam int NL = MAX_POINTS - k;

        logic signed [IN_W-1:0] r_out  [NL];
        logic                   r_lsat [NL];
        t_side                  r_sd   [LVL_LAT];
        logic                   r_vd   [LVL_LAT];
        t_side                  n_side;

        for (genvar i = 0; i < NL; i++) begin : g_lane
            logic signed [IN_W-1:0] n_num;
            logic signed [DX_W-1:0] n_den;
            logic signed [IN_W-1:0] r_num;
            logic signed [DX_W-1:0] r_den;
            logic [DIV_W-1:0]       n_dvd;
            logic [X_W-1:0]         n_dvs;
            logic                   n_neg;
            logic [DIV_W-1:0]       r_dvd;
            logic [X_W-1:0]         r_dvs;
            logic                   r_neg;
            logic [DIV_W-1:0]       w_quo;
            logic                   w_qneg;
            logic signed [IN_W-1:0] n_out;
            logic                   n_lsat;

            assign n_num = w_cur[k-1][i+1] - w_cur[k-1][i];
            assign n_den = $signed({1'b0, w_side[k-1].xs[i+k]})
                         - $signed({1'b0, w_side[k-1].xs[i]});

            // magnitudes; the first order scales its q.16 numerator up
            always_comb begin
                logic [IN_W-1:0] absn;
                logic [DX_W-1:0] absd;
                absn  = r_num[IN_W-1] ? IN_W'(-r_num) : IN_W'(r_num);
                absd  = r_den[DX_W-1] ? DX_W'(-r_den) : DX_W'(r_den);
                n_dvs = absd[X_W-1:0];
                n_neg = r_num[IN_W-1] ^ r_den[DX_W-1];
                if (k == 1) begin
                    n_dvd = DIV_W'(absn[SAMPLE_W:0]) << SHIFT;
                end else begin
                    n_dvd = DIV_W'(absn);
                end
            end

            always_ff @(posedge i_clk) begin
                r_num <= n_num;
                r_den <= n_den;
                r_dvd <= n_dvd;
                r_dvs <= n_dvs;
                r_neg <= n_neg;
            end

            ndd_div #(
                .DW  (DIV_W),
                .VW  (X_W),
                .BPS (DIV_BPS),
                .TW  (1)
            ) u_div (
                .i_clk      (i_clk),
                .i_dividend (r_dvd),
                .i_divisor  (r_dvs),
                .i_tag      (r_neg),
                .o_quotient (w_quo),
                .o_tag      (w_qneg)
            );

            // clamp to the inner range, then apply the sign
            always_comb begin
                logic [MAG_W-1:0] qc;
                n_lsat = w_quo > DIV_W'(INNER_LIM_U);
                qc     = n_lsat ? INNER_LIM_U[MAG_W-1:0] : w_quo[MAG_W-1:0];
                n_out  = w_qneg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
            end

            always_ff @(posedge i_clk) begin
                r_out[i]  <= n_out;
                r_lsat[i] <= n_lsat;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sd[0] <= w_side[k-1];
            for (int j = 1; j < LVL_LAT; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int j = 0; j < LVL_LAT; j++) begin
                    r_vd[j] <= 1'b0;
                end
            end else begin
                r_vd[0] <= w_vld[k-1];
                for (int j = 1; j < LVL_LAT; j++) begin
                    r_vd[j] <= r_vd[j-1];
                end
            end
        end

        // only entries built from used nodes may raise saturation
        always_comb begin
            n_side         = r_sd[LVL_LAT-1];
            n_side.coef[k] = r_out[0];
            for (int i = 0; i < NL; i++) begin
                if ((int'(r_sd[LVL_LAT-1].cnt) > i + k) && r_lsat[i]) begin
                    n_side.sat = 1'b1;
                end
            end
        end

        assign w_side[k] = n_side;
        assign w_vld[k]  = r_vd[LVL_LAT-1];
        for (genvar i = 0; i < MAX_POINTS; i++) begin : g_link
            if (i < NL) begin : g_used
                assign w_cur[k][i] = r_out[i];
            end else begin : g_none
                assign w_cur[k][i] = '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // horner steps for node k = count-2 down to 1
    // ---------------------------------------------------------------
    localparam int HSTEPS = MAX_POINTS - 2;

    logic signed [IN_W-1:0] w_hp [HSTEPS+1];
    t_side                  w_hs [HSTEPS+1];
    logic                   w_hv [HSTEPS+1];

    assign w_hp[0] = $signed(w_side[MAX_POINTS-1].coef[MAX_POINTS-1]);
    assign w_hs[0] = w_side[MAX_POINTS-1];
    assign w_hv[0] = w_vld[MAX_POINTS-1];

    for (genvar h = 0; h < HSTEPS; h++) begin : g_hrn
        localparam int KK = MAX_POINTS - 2 - h;

        logic [MAG_W-1:0]       n_up;
        logic [UM_W-1:0]        n_um;
        logic                   n_neg;
        logic [MAG_W-1:0]       r_up;
        logic [UM_W-1:0]        r_um;
        logic                   r_neg [3];
        logic [PROD_W-1:0]      w_prod;
        logic signed [IN_W-1:0] n_sp;
        logic                   n_msat;
        logic signed [IN_W-1:0] r_sp;
        logic                   r_msat;
        logic signed [IN_W-1:0] n_p;
        logic                   n_ssat;
        logic signed [IN_W-1:0] r_p;
        logic                   r_ssat;
        t_side                  r_hsd [HRN_LAT];
        logic                   r_hvd [HRN_LAT];
        t_side                  n_hs;

        always_comb begin
            logic signed [M_W-1:0]  m;
            logic [IN_W-1:0]        ap;
            logic [M_W-1:0]         am;
            m     = M_W'(w_hs[h].qx) - $signed({2'b00, w_hs[h].xs[KK]});
            ap    = w_hp[h][IN_W-1] ? IN_W'(-w_hp[h]) : IN_W'(w_hp[h]);
            am    = m[M_W-1] ? M_W'(-m) : M_W'(m);
            n_up  = ap[MAG_W-1:0];
            n_um  = am[UM_W-1:0];
            n_neg = w_hp[h][IN_W-1] ^ m[M_W-1];
        end

        always_ff @(posedge i_clk) begin
            r_up     <= n_up;
            r_um     <= n_um;
            r_neg[0] <= n_neg;
            r_neg[1] <= r_neg[0];
            r_neg[2] <= r_neg[1];
        end

        ndd_mul #(
            .AW (MAG_W),
            .BW (UM_W)
        ) u_mul (
            .i_clk (i_clk),
            .i_a   (r_up),
            .i_b   (r_um),
            .o_p   (w_prod)
        );

        always_comb begin
            logic [MAG_W-1:0] pm;
            n_msat = w_prod > PROD_W'(INNER_LIM_U);
            pm     = n_msat ? INNER_LIM_U[MAG_W-1:0] : w_prod[MAG_W-1:0];
            n_sp   = r_neg[2] ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
        end

        always_ff @(posedge i_clk) begin
            r_sp   <= n_sp;
            r_msat <= n_msat;
        end

        // add the coefficient and clamp; the top used step just loads it
        always_comb begin
            logic signed [IN_W-1:0] c;
            logic signed [IN_W-1:0] sum;
            logic                   csat;
            c    = $signed(r_hsd[3].coef[KK]);
            sum  = c + r_sp;
            csat = 1'b0;
            if (sum > $signed(INNER_LIM_U)) begin
                sum  = $signed(INNER_LIM_U);
                csat = 1'b1;
            end else if (sum < -$signed(INNER_LIM_U)) begin
                sum  = -$signed(INNER_LIM_U);
                csat = 1'b1;
            end
            if (int'(r_hsd[3].cnt) == KK + 1) begin
                n_p = c;
            end else begin
                n_p = sum;
            end
            n_ssat = (int'(r_hsd[3].cnt) > KK + 1) && (r_msat || csat);
        end

        always_ff @(posedge i_clk) begin
            r_p    <= n_p;
            r_ssat <= n_ssat;
        end

        always_ff @(posedge i_clk) begin
            r_hsd[0] <= w_hs[h];
            for (int j = 1; j < HRN_LAT; j++) begin
                r_hsd[j] <= r_hsd[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int j = 0; j < HRN_LAT; j++) begin
                    r_hvd[j] <= 1'b0;
                end
            end else begin
                r_hvd[0] <= w_hv[h];
                for (int j = 1; j < HRN_LAT; j++) begin
                    r_hvd[j] <= r_hvd[j-1];
                end
            end
        end

        always_comb begin
            n_hs     = r_hsd[HRN_LAT-1];
            n_hs.sat = r_hsd[HRN_LAT-1].sat | r_ssat;
        end

        assign w_hp[h+1] = r_p;
        assign w_hs[h+1] = n_hs;
        assign w_hv[h+1] = r_hvd[HRN_LAT-1];
    end

    // ---------------------------------------------------------------
    // final step: t = p * (query - x0) scaled back to q.16, plus y0
    // ---------------------------------------------------------------
    logic signed [IN_W-1:0] w_fp;
    t_side                  w_fs;

    assign w_fp = w_hp[HSTEPS];
    assign w_fs = w_hs[HSTEPS];

    logic [MAG_W-1:0]          n_fup;
    logic [UM_W-1:0]           n_fum;
    logic                      n_fneg;
    logic [MAG_W-1:0]          r_fup;
    logic [UM_W-1:0]           r_fum;
    logic                      r_fneg [3];
    logic [PROD_W-1:0]         w_fprod;
    logic signed [VALUE_W-1:0] n_t;
    logic                      n_tsat;
    logic signed [VALUE_W-1:0] r_t;
    logic                      r_tsat;
    t_side                     r_fsd [HRN_LAT-1];
    logic                      r_fvd [HRN_LAT-1];

    always_comb begin
        logic signed [M_W-1:0] m;
        logic [IN_W-1:0]       ap;
        logic [M_W-1:0]        am;
        m      = M_W'(w_fs.qx) - $signed({2'b00, w_fs.xs[0]});
        ap     = w_fp[IN_W-1] ? IN_W'(-w_fp) : IN_W'(w_fp);
        am     = m[M_W-1] ? M_W'(-m) : M_W'(m);
        n_fup  = ap[MAG_W-1:0];
        n_fum  = am[UM_W-1:0];
        n_fneg = w_fp[IN_W-1] ^ m[M_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_fup     <= n_fup;
        r_fum     <= n_fum;
        r_fneg[0] <= n_fneg;
        r_fneg[1] <= r_fneg[0];
        r_fneg[2] <= r_fneg[1];
    end

    ndd_mul #(
        .AW (MAG_W),
        .BW (UM_W)
    ) u_fmul (
        .i_clk (i_clk),
        .i_a   (r_fup),
        .i_b   (r_fum),
        .o_p   (w_fprod)
    );

    always_comb begin
        logic [PROD_W-1:0]  tsh;
        logic [VALUE_W-1:0] tm;
        tsh    = w_fprod >> SHIFT;
        n_tsat = tsh > PROD_W'(OUT_LIM_U);
        tm     = n_tsat ? OUT_LIM_U : tsh[VALUE_W-1:0];
        n_t    = r_fneg[2] ? -$signed(tm) : $signed(tm);
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_tsat <= n_tsat;
    end

    always_ff @(posedge i_clk) begin
        r_fsd[0] <= w_fs;
        for (int j = 1; j < HRN_LAT - 1; j++) begin
            r_fsd[j] <= r_fsd[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HRN_LAT - 1; j++) begin
                r_fvd[j] <= 1'b0;
            end
        end else begin
            r_fvd[0] <= w_hv[HSTEPS];
            for (int j = 1; j < HRN_LAT - 1; j++) begin
                r_fvd[j] <= r_fvd[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic signed [VALUE_W-1:0] n_value;
    t_status                   n_status;
    logic                      r_strobe;
    logic signed [VALUE_W-1:0] r_value;
    t_status                   r_status;

    always_comb begin
        logic signed [VALUE_W:0] v;
        logic                    vsat;
        v    = $signed(r_fsd[HRN_LAT-2].coef[0][VALUE_W:0]) + (VALUE_W+1)'(r_t);
        vsat = v[VALUE_W] != v[VALUE_W-1];
        if (vsat) begin
            n_value = v[VALUE_W] ? $signed(~OUT_LIM_U) : $signed(OUT_LIM_U);
        end else begin
            n_value = v[VALUE_W-1:0];
        end
        priority if (r_fsd[HRN_LAT-2].bad) begin
            n_value  = '0;
            n_status = ST_BAD_COUNT;
        end else if (r_fsd[HRN_LAT-2].dup) begin
            n_value  = '0;
            n_status = ST_REPEAT;
        end else if (vsat || r_tsat || r_fsd[HRN_LAT-2].sat) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_fvd[HRN_LAT-2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_strobe = r_strobe;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// File: tb/newton_divided_difference_interp_top_test.sv
module newton_divided_difference_interp_top_test;
    import ndd_pkg::*;

    // pipe latency of the block plus some margin, used before config writes
    localparam int DRAIN_CYCLES = 110;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = REG_SAMPLE_0 + 3'd5;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic [CNT_W-1:0]          i_point_count;
    logic [SEL_W-1:0]          i_node_0;
    logic [SEL_W-1:0]          i_node_1;
    logic [SEL_W-1:0]          i_node_2;
    logic [SEL_W-1:0]          i_node_3;
    logic [SEL_W-1:0]          i_node_4;
    logic signed [QX_W-1:0]    i_query_x;
    logic                      o_strobe;
    logic signed [VALUE_W-1:0] o_value;
    logic [STATUS_W-1:0]       o_status;

    newton_divided_difference_interp_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_point_count(i_point_count), .i_node_0(i_node_0), .i_node_1(i_node_1),
        .i_node_2(i_node_2), .i_node_3(i_node_3), .i_node_4(i_node_4),
        .i_query_x(i_query_x), .o_strobe(o_strobe), .o_value(o_value),
        .o_status(o_status)
    );

    // one expected result word
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
    } interp_result_t;

    interp_result_t pending_results[$];

    // local copy of the register file
    logic [SPACE_W-1:0]         spacing_copy;
    logic signed [SAMPLE_W-1:0] sample_copy [MAX_POINTS];

    int words_sent;
    int results_seen;
    int mismatch_count;
    int sat_seen;
    int idle_pct;  // 0 during the no-idle stretch

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // (num * 2^sh) / den truncated toward zero, magnitude limited
    function automatic longint fixed_quotient(longint num, longint den, int sh,
                                              inout logic sat);
        logic [63:0] un, ud, q, r, b;
        logic        neg;
        un  = abs64(num);
        ud  = abs64(den);
        q   = un / ud;
        r   = un % ud;
        neg = (num < 0) != (den < 0);
        if (q > INNER_LIM_U) begin
            sat = 1'b1;
            q   = INNER_LIM_U;
        end else begin
            for (int i = 0; i < sh; i++) begin
                r = r << 1;
                b = (r >= ud) ? 64'd1 : 64'd0;
                if (b != 0) r = r - ud;
                if (q > ((INNER_LIM_U - b) >> 1)) begin
                    sat = 1'b1;
                    q   = INNER_LIM_U;
                    break;
                end
                q = (q << 1) + b;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamped_product(longint a, longint m, inout logic sat);
        logic [63:0] ua, um, p;
        ua = abs64(a);
        um = abs64(m);
        if (um != 0 && ua > INNER_LIM_U / um) begin
            sat = 1'b1;
            p   = INNER_LIM_U;
        end else begin
            p = ua * um;
        end
        return ((a < 0) != (m < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic interp_result_t newton_value(logic [CNT_W-1:0] cnt,
                                                    logic [SEL_W-1:0] sel [MAX_POINTS],
                                                    logic signed [QX_W-1:0] qx);
        interp_result_t res;
        longint         xs [MAX_POINTS];
        longint         cur [MAX_POINTS];
        longint         coef [MAX_POINTS];
        longint         q, p, t, val, lim;
        logic [63:0]    up, um, hi, lo, ut;
        logic           sat;
        int             n;
        n   = int'(cnt);
        q   = longint'(qx);
        sat = 1'b0;
        lim = longint'(INNER_LIM_U);
        res.value = '0;
        if (n < 2 || n > MAX_POINTS) begin
            res.status = ST_BAD_COUNT;
            return res;
        end
        for (int i = 0; i < n; i++) begin
            xs[i]  = longint'(sel[i]) * longint'(spacing_copy);
            cur[i] = (sel[i] < NODE_LIM) ? longint'(sample_copy[sel[i]]) : 0;
        end
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (xs[i] == xs[j]) begin
                    res.status = ST_REPEAT;
                    return res;
                end
        // divided-difference tableau, first order carries the extra fraction bits
        coef[0] = cur[0];
        for (int k = 1; k < n; k++) begin
            for (int i = 0; i + k < n; i++)
                cur[i] = fixed_quotient(cur[i+1] - cur[i], xs[i+k] - xs[i],
                                        (k == 1) ? SHIFT : 0, sat);
            coef[k] = cur[0];
        end
        // horner down to order one
        p = coef[n-1];
        for (int k = n - 2; k >= 1; k--) begin
            p = coef[k] + clamped_product(p, q - xs[k], sat);
            if (p > lim) begin sat = 1'b1; p = lim; end
            if (p < -lim) begin sat = 1'b1; p = -lim; end
        end
        // last step scales back to q.16
        up = abs64(p);
        um = abs64(q - xs[0]);
        hi = up >> SHIFT;
        lo = up & ((64'd1 << SHIFT) - 64'd1);
        if (um != 0 && hi > 64'(OUT_LIM_U) / um) begin
            sat = 1'b1;
            ut  = 64'(OUT_LIM_U);
        end else begin
            ut = hi * um + ((lo * um) >> SHIFT);
            if (ut > 64'(OUT_LIM_U)) begin
                sat = 1'b1;
                ut  = 64'(OUT_LIM_U);
            end
        end
        t   = ((p < 0) != ((q - xs[0]) < 0)) ? -longint'(ut) : longint'(ut);
        val = coef[0] + t;
        if (val > longint'(OUT_LIM_U)) begin sat = 1'b1; val = longint'(OUT_LIM_U); end
        if (val < -longint'(OUT_LIM_U) - 1) begin
            sat = 1'b1;
            val = -longint'(OUT_LIM_U) - 1;
        end
        res.value  = val[VALUE_W-1:0];
        res.status = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        interp_result_t want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: value %0d status %0d",
                             o_value, o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_status == ST_SAT) sat_seen++;
                if (o_value !== want.value || o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected value %0d status %0d, got %0d %0d",
                                 results_seen, want.value, want.status, o_value, o_status);
                end
            end
        end
    end

    // ---------------- drivers ----------------

    // hold start high until the word is taken, then log its expected result
    task automatic send_word(logic [CNT_W-1:0] cnt, logic [SEL_W-1:0] sel [MAX_POINTS],
                             logic signed [QX_W-1:0] qx);
        start         <= 1'b1;
        i_point_count <= cnt;
        i_node_0      <= sel[0];
        i_node_1      <= sel[1];
        i_node_2      <= sel[2];
        i_node_3      <= sel[3];
        i_node_4      <= sel[4];
        i_query_x     <= qx;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(newton_value(cnt, sel, qx));
        words_sent++;
        // random idle cycle before the next word
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_pipe;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_NODE_SPACING) spacing_copy = data[SPACE_W-1:0];
        else if (idx >= REG_SAMPLE_0 && idx < REG_PAST_LAST)
            sample_copy[idx - REG_SAMPLE_0] = data;
    endtask

    task automatic load_table(logic [SPACE_W-1:0] spc, logic [SAMPLE_W-1:0] s0,
                              logic [SAMPLE_W-1:0] s1, logic [SAMPLE_W-1:0] s2,
                              logic [SAMPLE_W-1:0] s3, logic [SAMPLE_W-1:0] s4);
        drain_pipe();
        write_reg(REG_NODE_SPACING, CFG_DATA_W'(spc));
        write_reg(REG_SAMPLE_0,        s0);
        write_reg(REG_SAMPLE_0 + 3'd1, s1);
        write_reg(REG_SAMPLE_0 + 3'd2, s2);
        write_reg(REG_SAMPLE_0 + 3'd3, s3);
        write_reg(REG_SAMPLE_0 + 3'd4, s4);
    endtask

    // shorthand for directed words
    task automatic word5(int cnt, int a, int b, int c, int d, int e, int qx);
        logic [SEL_W-1:0] sel [MAX_POINTS];
        sel = '{SEL_W'(a), SEL_W'(b), SEL_W'(c), SEL_W'(d), SEL_W'(e)};
        send_word(CNT_W'(cnt), sel, QX_W'(qx));
    endtask

    // mostly distinct in-table nodes near the table span, some noise
    task automatic random_word;
        logic [SEL_W-1:0]       sel [MAX_POINTS];
        logic [CNT_W-1:0]       cnt;
        logic signed [QX_W-1:0] qx;
        int                     k, tmp, span;
        sel = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
        for (int i = MAX_POINTS - 1; i > 0; i--) begin
            k = $urandom_range(i);
            tmp = sel[i]; sel[i] = sel[k]; sel[k] = SEL_W'(tmp);
        end
        cnt = CNT_W'($urandom_range(5, 2));
        if ($urandom_range(9) == 0) sel[$urandom_range(4)] = SEL_W'($urandom_range(7, 5));
        if ($urandom_range(9) == 0) begin
            // noise: any bits at all
            cnt = CNT_W'($urandom);
            for (int i = 0; i < MAX_POINTS; i++) sel[i] = SEL_W'($urandom);
        end
        span = 5 * int'(spacing_copy);
        if (span > 1048575) span = 1048575;
        if ($urandom_range(3) == 0) qx = QX_W'($urandom);
        else qx = QX_W'($urandom_range(span) - span / 8);
        send_word(cnt, sel, qx);
    endtask

    // ---------------- tests ----------------

    task automatic test_default_table;
        word5(2, 0, 1, 0, 0, 0, 10000);
        word5(3, 0, 1, 2, 0, 0, 30000);
        word5(4, 0, 1, 2, 3, 0, 50000);
        word5(5, 0, 1, 2, 3, 4, 70000);
        word5(5, 4, 3, 2, 1, 0, 0);
        word5(5, 2, 0, 4, 1, 3, -1048576);
        word5(5, 1, 3, 0, 4, 2, 1048575);
    endtask

    task automatic test_bad_count_repeat_and_stray_nodes;
        word5(0, 0, 1, 2, 3, 4, 5);
        word5(1, 0, 1, 2, 3, 4, 5);
        word5(6, 0, 1, 2, 3, 4, 5);
        word5(7, 7, 7, 7, 7, 7, -1);
        word5(2, 3, 3, 0, 0, 0, 100);     // equal selectors
        word5(5, 0, 1, 2, 3, 1, 100);     // repeat in the last node
        word5(3, 0, 1, 2, 2, 2, 100);     // unused selectors repeat, fine
        word5(3, 5, 6, 7, 0, 0, 120000);  // selectors past the table
        word5(2, 7, 0, 0, 0, 0, 0);
        // zero spacing makes every pair coincide
        load_table(18'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5);
        word5(2, 0, 1, 0, 0, 0, 7);
        word5(5, 4, 3, 2, 1, 0, 7);
    endtask

    task automatic test_saturation_extremes;
        load_table(18'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF);
        word5(2, 0, 1, 0, 0, 0, 1048575);
        word5(5, 0, 1, 2, 3, 4, -1048576);
        word5(5, 4, 0, 2, 1, 3, 1048575);
        word5(3, 0, 2, 4, 0, 0, 1);
        load_table(18'h3FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1);
        write_reg(REG_PAST_LAST, 32'hDEAD_BEEF);  // ignored by the block
        word5(5, 0, 1, 2, 3, 4, 1048575);
        word5(4, 3, 1, 0, 2, 0, -1048576);
        word5(2, 7, 6, 0, 0, 0, 0);
    endtask

    task automatic test_random_tables;
        logic [SPACE_W-1:0] spc;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: spc = SPACE_W'($urandom_range(20000, 1000));
                1: spc = SPACE_W'($urandom_range(16, 1));
                2: spc = 18'h3FFFF;
                default: spc = SPACE_W'($urandom);
            endcase
            if (spc == 0) spc = 18'd1;
            load_table(spc, $urandom, $urandom, $urandom_range(700000, 600000),
                       $urandom_range(700000, 600000), $urandom);
            idle_pct = (ph == 2) ? 0 : 20;  // one long stretch at full rate
            repeat (225) random_word();
        end
        idle_pct = 20;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_point_count <= '0;
        i_node_0      <= '0;
        i_node_1      <= '0;
        i_node_2      <= '0;
        i_node_3      <= '0;
        i_node_4      <= '0;
        i_query_x     <= '0;
        spacing_copy   = SPACING_RST;
        for (int i = 0; i < MAX_POINTS; i++) sample_copy[i] = SAMPLE_RST[i];
        words_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        sat_seen       = 0;
        idle_pct       = 20;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_table();
        test_bad_count_repeat_and_stray_nodes();
        test_saturation_extremes();
        test_random_tables();

        drain_pipe();
        if (pending_results.size() != 0) mismatch_count++;
        $display("covered %0d words over 9 register settings, %0d results, %0d saturated",
                 words_sent, results_seen, sat_seen);
        if (mismatch_count == 0)
            $display("newton_divided_difference_interp_top: match");
        else
            $display("newton_divided_difference_interp_top: mismatch");
        $finish;
    end

    // run limit, far above the expected run time
    initial begin
        #4000000;
        $display("newton_divided_difference_interp_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/ndd_pkg.sv
rtl/ndd_div.sv
rtl/ndd_mul.sv
rtl/newton_divided_difference_interp_top.sv
tb/newton_divided_difference_interp_top_test.sv
